FILE: rtl/css_pkg.sv
// shared types, constants and calendar helpers for the cron schedule stepper
package css_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    // mask widths
    localparam int MINUTE_N = 60;
    localparam int HOUR_N   = 24;
    localparam int MDAY_N   = 31;
    localparam int MONTH_N  = 12;
    localparam int WDAY_N   = 7;

    localparam int SEARCH_LIMIT_DEF = 4096;

    // year bounds
    localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_LAST  = 14'd9999;

    // pipeline depth of the calendar unit
    localparam int CAL_LAT = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd1;
    localparam logic [OP_W-1:0] OP_PREV = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MDAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WDAY   = 3'd4;

    // unit levels, year is the root
    localparam logic [2:0] LV_YEAR   = 3'd0;
    localparam logic [2:0] LV_MONTH  = 3'd1;
    localparam logic [2:0] LV_DAY    = 3'd2;
    localparam logic [2:0] LV_HOUR   = 3'd3;
    localparam logic [2:0] LV_MINUTE = 3'd4;

    // cell commands
    localparam logic [2:0] CELL_NOP     = 3'd0;
    localparam logic [2:0] CELL_LOAD    = 3'd1;
    localparam logic [2:0] CELL_SAVE    = 3'd2;
    localparam logic [2:0] CELL_SEEK    = 3'd3;
    localparam logic [2:0] CELL_EDGE    = 3'd4;
    localparam logic [2:0] CELL_RESTORE = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       fwd;
    } cell_ctl_t;

    typedef struct packed {
        logic found;
        logic nonempty;
    } cell_stat_t;

    // days in a valid month of a common year
    function automatic logic [5:0] month_len(input logic [MONTH_W-1:0] m);
        logic [5:0] r;
        unique case (m)
            4'd2:                      r = 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 6'd30;
            default:                   r = 6'd31;
        endcase
        return r;
    endfunction

    // weekday offset of day one for the month
    function automatic logic [2:0] wk_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        unique case (m)
            4'd2:  r = 3'd3;
            4'd3:  r = 3'd2;
            4'd4:  r = 3'd5;
            4'd5:  r = 3'd0;
            4'd6:  r = 3'd3;
            4'd7:  r = 3'd5;
            4'd8:  r = 3'd1;
            4'd9:  r = 3'd4;
            4'd10: r = 3'd6;
            4'd11: r = 3'd2;
            4'd12: r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/css_if.sv
// word channels of the cron schedule stepper
interface css_in_if;
    import css_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [YEAR_W-1:0]   load_year;
    logic [MONTH_W-1:0]  load_month;
    logic [DAY_W-1:0]    load_day;
    logic [HOUR_W-1:0]   load_hour;
    logic [MINUTE_W-1:0] load_minute;

    modport source (output valid, operation, load_year, load_month, load_day,
                    load_hour, load_minute, input ready);
    modport sink   (input valid, operation, load_year, load_month, load_day,
                    load_hour, load_minute, output ready);
endinterface

interface css_out_if;
    import css_pkg::*;
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic [HOUR_W-1:0]   out_hour;
    logic [MINUTE_W-1:0] out_minute;
    logic                no_match;

    modport source (output valid, out_year, out_month, out_day, out_hour,
                    out_minute, no_match, input ready);
    modport sink   (input valid, out_year, out_month, out_day, out_hour,
                    out_minute, no_match, output ready);
endinterface

FILE: rtl/css_unit_cell.sv
// one calendar unit cell: value, saved copy, seek and edge selection
module css_unit_cell
    import css_pkg::*;
#(
    parameter int W = 6,
    parameter int N = 60,
    parameter int LO = 0,
    parameter int RESET_VAL = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cell_ctl_t    ctl,
    input  logic [N-1:0] allowed,
    input  logic [W-1:0] load_value,
    output logic [W-1:0] value,
    output cell_stat_t   stat
);

    logic [W-1:0] value_reg, value_next;
    logic [W-1:0] save_reg, save_next;
    logic [W-1:0] seek_val, edge_val;
    logic         seek_hit;

    // next value above or last value below the current one
    always_comb
    begin
        seek_val = value_reg;
        seek_hit = 1'b0;
        if (ctl.fwd)
        begin
            for (int p = N - 1; p >= 0; p--)
            begin
                if (allowed[p] && (7'(p + LO) > 7'(value_reg)))
                begin
                    seek_val = W'(p + LO);
                    seek_hit = 1'b1;
                end
            end
        end
        else
        begin
            for (int p = 0; p < N; p++)
            begin
                if (allowed[p] && (7'(p + LO) < 7'(value_reg)))
                begin
                    seek_val = W'(p + LO);
                    seek_hit = 1'b1;
                end
            end
        end
    end

    // first allowed value going forward, last going back
    always_comb
    begin
        edge_val = value_reg;
        if (ctl.fwd)
        begin
            for (int p = N - 1; p >= 0; p--)
            begin
                if (allowed[p])
                begin
                    edge_val = W'(p + LO);
                end
            end
        end
        else
        begin
            for (int p = 0; p < N; p++)
            begin
                if (allowed[p])
                begin
                    edge_val = W'(p + LO);
                end
            end
        end
    end

    // command decode
    always_comb
    begin
        value_next = value_reg;
        save_next  = save_reg;
        unique case (ctl.op)
            CELL_LOAD:    value_next = load_value;
            CELL_SAVE:    save_next  = value_reg;
            CELL_SEEK:    value_next = seek_val;
            CELL_EDGE:    value_next = edge_val;
            CELL_RESTORE: value_next = save_reg;
            default:      value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= W'(RESET_VAL);
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        save_reg <= save_next;
    end

    assign value         = value_reg;
    assign stat.found    = seek_hit;
    assign stat.nonempty = |allowed;

endmodule

FILE: rtl/css_calendar.sv
// pipelined month length and weekday unit, and allowed day set
module css_calendar
    import css_pkg::*;
(
    input  logic                clk,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  logic [MDAY_N-1:0]   mday_mask,
    input  logic [WDAY_N-1:0]   wday_mask,
    output logic [MDAY_N-1:0]   day_set
);

    // stage one: shifted year and reciprocal products for /100
    logic [14:0] yy1_reg, yy1_next;
    logic [YEAR_W-1:0] y1_reg;
    logic [MONTH_W-1:0] m1_reg;
    logic [23:0] pa1_reg;
    logic [22:0] pb1_reg;

    // stage two to four
    logic [15:0] sum2_reg, sum2_next, sum3_reg;
    logic [5:0]  dim2_reg, dim2_next, dim3_reg, dim4_reg;
    logic [31:0] p7_3_reg;
    logic [2:0]  w4_reg, w4_next;

    logic [8:0]  q100, q400;
    logic [7:0]  qy;
    logic [YEAR_W-1:0] r100;
    logic        leap, mvalid;
    logic [14:0] q7;
    logic [15:0] rem7;

    always_comb
    begin
        yy1_next = 15'({1'b0, year}) + 15'd400 - ((month < 4'd3) ? 15'd1 : 15'd0);
    end

    always_ff @(posedge clk)
    begin
        yy1_reg <= yy1_next;
        y1_reg  <= year;
        m1_reg  <= month;
        pa1_reg <= 24'(yy1_next[14:2]) * 24'd1311;
        pb1_reg <= 23'(year[13:2]) * 23'd1311;
    end

    // stage two: weekday sum and month length
    always_comb
    begin
        q100   = 9'(pa1_reg[23:15]);
        q400   = q100 >> 2;
        qy     = pb1_reg[22:15];
        r100   = y1_reg - 14'(qy * 14'd100);
        leap   = (y1_reg[1:0] == 2'd0) && ((r100 != '0) || (qy[1:0] == 2'd0));
        mvalid = (m1_reg >= 4'd1) && (m1_reg <= 4'd12);
        sum2_next = 16'(yy1_reg) + 16'(yy1_reg[14:2]) - 16'(q100) + 16'(q400)
                    + 16'(wk_offset(m1_reg)) + 16'd1;
        if (!mvalid)
        begin
            dim2_next = 6'd0;
        end
        else if (m1_reg == 4'd2 && leap)
        begin
            dim2_next = 6'd29;
        end
        else
        begin
            dim2_next = month_len(m1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        sum2_reg <= sum2_next;
        dim2_reg <= dim2_next;
    end

    // stage three: reciprocal product for mod 7
    always_ff @(posedge clk)
    begin
        p7_3_reg <= 32'(sum2_reg) * 32'd18725;
        sum3_reg <= sum2_reg;
        dim3_reg <= dim2_reg;
    end

    // stage four: weekday of day one
    always_comb
    begin
        q7   = p7_3_reg[31:17];
        rem7 = sum3_reg - 16'(16'(q7) * 16'd7);
        w4_next = rem7[2:0];
    end

    always_ff @(posedge clk)
    begin
        w4_reg   <= w4_next;
        dim4_reg <= dim3_reg;
    end

    // allowed days under cron rules
    logic [WDAY_N-1:0] rot;
    logic [MDAY_N-1:0] lim, md, wd;
    logic [3:0]        ws;
    logic              mfull, wfull;

    always_comb
    begin
        for (int k = 0; k < WDAY_N; k++)
        begin
            ws = 4'(w4_reg) + 4'(k);
            if (ws >= 4'd7)
            begin
                ws = ws - 4'd7;
            end
            rot[k] = wday_mask[ws[2:0]];
        end
        for (int d = 0; d < MDAY_N; d++)
        begin
            lim[d] = (6'(d) < dim4_reg);
            wd[d]  = rot[d % WDAY_N] & lim[d];
        end
        md    = mday_mask & lim;
        mfull = &mday_mask;
        wfull = &wday_mask;
        if (mfull && !wfull)
        begin
            day_set = wd;
        end
        else if (!mfull && !wfull)
        begin
            day_set = md | wd;
        end
        else
        begin
            day_set = md;
        end
    end

endmodule

FILE: rtl/cron_schedule_stepper_core.sv
// top level of the cron schedule stepper: sequencer, year unit and cell row
//
// Holds one calendar time (year, month, day, hour, minute) and walks it over
// the times that the five cron masks allow.
// Input channel in_ch: one word per command. Load sets the time, step-next
// and step-back move to the next or previous allowed minute.
// Output channel out_ch: one word per command with the time after it and
// no_match, which is set when the search limit or a year bound was hit;
// the time is then left as it was before the step.
// Configuration: cfg_we with cfg_index and cfg_data writes one mask; write
// only while the block is idle.
// Flow: load and the unused code pass through the response state into the
// output register. A step moves or resets one unit at a time, waits for the
// calendar pipeline each time the month or year changes before the day unit
// is used, and ends in the response state; a search that runs to its limit
// or a year bound goes through the restore state first.
// One command is in work at a time; the next is taken once the word is
// loaded into the output register.
// Reset: time 1970-01-01 00:00, all masks allow everything.
// A stalled receiver holds the word in the output register; the block can take
// the next command but waits in the response state until that word is free again.
module cron_schedule_stepper_core
    import css_pkg::*;
#(
    parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    css_in_if.sink                in_ch,
    css_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ITER_W = $clog2(SEARCH_LIMIT + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MOVE    = 3'd1;
    localparam logic [2:0] ST_CHILD   = 3'd2;
    localparam logic [2:0] ST_RESTORE = 3'd3;
    localparam logic [2:0] ST_RESP    = 3'd4;

    // configuration masks
    logic [MINUTE_N-1:0] minute_mask_reg;
    logic [HOUR_N-1:0]   hour_mask_reg;
    logic [MDAY_N-1:0]   mday_mask_reg;
    logic [MONTH_N-1:0]  month_mask_reg;
    logic [WDAY_N-1:0]   wday_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_mask_reg <= '1;
            hour_mask_reg   <= '1;
            mday_mask_reg   <= '1;
            month_mask_reg  <= '1;
            wday_mask_reg   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MINUTE: minute_mask_reg <= cfg_data[MINUTE_N-1:0];
                REG_HOUR:   hour_mask_reg   <= cfg_data[HOUR_N-1:0];
                REG_MDAY:   mday_mask_reg   <= cfg_data[MDAY_N-1:0];
                REG_MONTH:  month_mask_reg  <= cfg_data[MONTH_N-1:0];
                REG_WDAY:   wday_mask_reg   <= cfg_data[WDAY_N-1:0];
                default:    ;
            endcase
        end
    end

    // allowed sets, an empty minute, hour or month mask allows everything
    logic [MINUTE_N-1:0] minute_set;
    logic [HOUR_N-1:0]   hour_set;
    logic [MONTH_N-1:0]  month_set;
    logic [MDAY_N-1:0]   day_set;

    assign minute_set = (minute_mask_reg == '0) ? '1 : minute_mask_reg;
    assign hour_set   = (hour_mask_reg == '0)   ? '1 : hour_mask_reg;
    assign month_set  = (month_mask_reg == '0)  ? '1 : month_mask_reg;

    // sequencer registers
    logic [2:0]        state_reg, state_next;
    logic [2:0]        pos_reg, pos_next;
    logic [ITER_W-1:0] iters_reg, iters_next;
    logic              fwd_reg, fwd_next;
    logic              fail_reg, fail_next;
    logic [2:0]        cal_wait_reg, cal_wait_next;
    logic [YEAR_W-1:0] year_reg, year_next, year_save_reg;
    logic              year_save;

    cell_ctl_t  ctl [5];
    cell_stat_t stat [5];
    logic [MONTH_W-1:0]  month_val;
    logic [DAY_W-1:0]    day_val;
    logic [HOUR_W-1:0]   hour_val;
    logic [MINUTE_W-1:0] minute_val;

    logic in_fire, out_slot, load_out, active, cal_touch;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_slot    = !out_ch.valid || out_ch.ready;

    // year has no cell of its own
    assign stat[0].found    = 1'b0;
    assign stat[0].nonempty = 1'b1;

    // step sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        iters_next = iters_reg;
        fwd_next   = fwd_reg;
        fail_next  = fail_reg;
        year_next  = year_reg;
        year_save  = 1'b0;
        cal_touch  = 1'b0;
        load_out   = 1'b0;
        active     = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            ctl[i].op  = CELL_NOP;
            ctl[i].fwd = fwd_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    fail_next  = 1'b0;
                    state_next = ST_RESP;
                    unique case (in_ch.operation)
                        OP_LOAD:
                        begin
                            for (int i = 1; i < 5; i++)
                            begin
                                ctl[i].op = CELL_LOAD;
                            end
                            year_next = in_ch.load_year;
                            cal_touch = 1'b1;
                        end
                        OP_NEXT, OP_PREV:
                        begin
                            for (int i = 1; i < 5; i++)
                            begin
                                ctl[i].op = CELL_SAVE;
                            end
                            year_save  = 1'b1;
                            fwd_next   = (in_ch.operation == OP_NEXT);
                            iters_next = '0;
                            pos_next   = LV_MINUTE;
                            state_next = ST_MOVE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOVE:
            begin
                active = !(pos_reg == LV_DAY && cal_wait_reg != '0);
                if (active)
                begin
                    iters_next = iters_reg + 1'b1;
                    if (iters_reg == ITER_W'(SEARCH_LIMIT))
                    begin
                        state_next = ST_RESTORE;
                    end
                    else if (pos_reg == LV_YEAR)
                    begin
                        if (fwd_reg ? (year_reg >= YEAR_LAST) : (year_reg <= YEAR_FIRST))
                        begin
                            state_next = ST_RESTORE;
                        end
                        else
                        begin
                            year_next  = fwd_reg ? year_reg + 1'b1 : year_reg - 1'b1;
                            cal_touch  = 1'b1;
                            pos_next   = LV_MONTH;
                            state_next = ST_CHILD;
                        end
                    end
                    else if (stat[pos_reg].found)
                    begin
                        ctl[pos_reg].op = CELL_SEEK;
                        cal_touch = (pos_reg == LV_MONTH);
                        if (pos_reg == LV_MINUTE)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            pos_next   = pos_reg + 1'b1;
                            state_next = ST_CHILD;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            ST_CHILD:
            begin
                active = !(pos_reg == LV_DAY && cal_wait_reg != '0);
                if (active)
                begin
                    if (!stat[pos_reg].nonempty)
                    begin
                        pos_next   = pos_reg - 1'b1;
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        ctl[pos_reg].op = CELL_EDGE;
                        cal_touch = (pos_reg == LV_MONTH);
                        if (pos_reg == LV_MINUTE)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end
            ST_RESTORE:
            begin
                for (int i = 1; i < 5; i++)
                begin
                    ctl[i].op = CELL_RESTORE;
                end
                year_next  = year_save_reg;
                cal_touch  = 1'b1;
                fail_next  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_slot)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // calendar settle counter
        if (cal_touch)
        begin
            cal_wait_next = 3'(CAL_LAT);
        end
        else if (cal_wait_reg != '0)
        begin
            cal_wait_next = cal_wait_reg - 1'b1;
        end
        else
        begin
            cal_wait_next = cal_wait_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= LV_MINUTE;
            iters_reg    <= '0;
            fwd_reg      <= 1'b1;
            fail_reg     <= 1'b0;
            cal_wait_reg <= 3'(CAL_LAT);
            year_reg     <= YEAR_FIRST;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            iters_reg    <= iters_next;
            fwd_reg      <= fwd_next;
            fail_reg     <= fail_next;
            cal_wait_reg <= cal_wait_next;
            year_reg     <= year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (year_save)
        begin
            year_save_reg <= year_reg;
        end
    end

    // calendar unit
    css_calendar u_cal (
        .clk       (clk),
        .year      (year_reg),
        .month     (month_val),
        .mday_mask (mday_mask_reg),
        .wday_mask (wday_mask_reg),
        .day_set   (day_set)
    );

    // row of unit cells, month down to minute
    css_unit_cell #(.W(MONTH_W), .N(MONTH_N), .LO(1), .RESET_VAL(1)) u_month (
        .clk(clk), .rst_n(rst_n), .ctl(ctl[1]), .allowed(month_set),
        .load_value(in_ch.load_month), .value(month_val), .stat(stat[1])
    );

    css_unit_cell #(.W(DAY_W), .N(MDAY_N), .LO(1), .RESET_VAL(1)) u_day (
        .clk(clk), .rst_n(rst_n), .ctl(ctl[2]), .allowed(day_set),
        .load_value(in_ch.load_day), .value(day_val), .stat(stat[2])
    );

    css_unit_cell #(.W(HOUR_W), .N(HOUR_N), .LO(0), .RESET_VAL(0)) u_hour (
        .clk(clk), .rst_n(rst_n), .ctl(ctl[3]), .allowed(hour_set),
        .load_value(in_ch.load_hour), .value(hour_val), .stat(stat[3])
    );

    css_unit_cell #(.W(MINUTE_W), .N(MINUTE_N), .LO(0), .RESET_VAL(0)) u_minute (
        .clk(clk), .rst_n(rst_n), .ctl(ctl[4]), .allowed(minute_set),
        .load_value(in_ch.load_minute), .value(minute_val), .stat(stat[4])
    );

    // output word register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch.out_year   <= year_reg;
            out_ch.out_month  <= month_val;
            out_ch.out_day    <= day_val;
            out_ch.out_hour   <= hour_val;
            out_ch.out_minute <= minute_val;
            out_ch.no_match   <= fail_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

    // a word is loaded only from the response state
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("output word loaded outside response state");

    // a step starts its search at the minute unit
    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.operation == OP_NEXT || in_ch.operation == OP_PREV))
        |=> (state_reg == ST_MOVE && pos_reg == LV_MINUTE && iters_reg == '0))
        else $error("step did not start at minute level");

    // hitting the search limit restores the time
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE && active && iters_reg == ITER_W'(SEARCH_LIMIT))
        |=> state_reg == ST_RESTORE)
        else $error("search limit not honoured");

    // the day unit is used only with a settled calendar
    a_cal_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl[2].op == CELL_SEEK || ctl[2].op == CELL_EDGE) |-> cal_wait_reg == '0)
        else $error("day unit used before calendar settled");

endmodule
